// ----- rtl/core/nfl_pkg.sv -----
// shared types and constants of the nearest fragment label block
package nfl_pkg;

   localparam int POS_W    = 10;
   localparam int TAG_W    = 16;
   localparam int STATUS_W = 3;
   localparam int INDEX_W  = 6;
   localparam int MODE_W   = 2;
   localparam int CMD_W    = 2;

   localparam int MAX_FRAGMENTS_DEF = 64;
   localparam int COORD_BITS_DEF    = 10;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_APPEND   = 2'd1,
      CMD_CLASSIFY = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_CLASSIFIED = 3'd0,
      STAT_EMPTY      = 3'd1,
      STAT_STORED     = 3'd2,
      STAT_FULL       = 3'd3,
      STAT_CLEARED    = 3'd4
   } status_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_EUCLID    = 2'd0,
      MODE_MANHATTAN = 2'd1,
      MODE_CHEBYSHEV = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TERM,
      ST_DIST,
      ST_LAUNCH,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic append;
      logic launch;
   } row_ctrl_type;

endpackage

// ----- rtl/core/nfl_cell.sv -----
// one table cell: stores a fragment, works out its distance, updates the passing best candidate
module nfl_cell #(
   parameter int INDEX      = 0,
   parameter int COORD_BITS = nfl_pkg::COORD_BITS_DEF,
   parameter int IDX_W      = 6,
   parameter int CNT_W      = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [nfl_pkg::MODE_W-1:0]  mode,
   input  logic [COORD_BITS-1:0]       seed_x,
   input  logic [COORD_BITS-1:0]       seed_y,
   input  logic [COORD_BITS-1:0]       seed_z,
   input  logic                        append,
   input  logic [CNT_W-1:0]            count,
   input  logic [COORD_BITS-1:0]       wr_x,
   input  logic [COORD_BITS-1:0]       wr_y,
   input  logic [COORD_BITS-1:0]       wr_z,
   input  logic [nfl_pkg::TAG_W-1:0]   wr_tag,
   input  logic                        src_valid,
   input  logic [2*COORD_BITS+1:0]     src_dist,
   input  logic [IDX_W-1:0]            src_idx,
   input  logic [nfl_pkg::TAG_W-1:0]   src_tag,
   output logic                        dst_valid,
   output logic [2*COORD_BITS+1:0]     dst_dist,
   output logic [IDX_W-1:0]            dst_idx,
   output logic [nfl_pkg::TAG_W-1:0]   dst_tag
);
   import nfl_pkg::*;

   localparam int TERM_W = 2 * COORD_BITS;
   localparam int DIST_W = TERM_W + 2;

   function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
      logic [COORD_BITS-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return d;
   endfunction

   function automatic logic [TERM_W-1:0] axis_term(input logic [COORD_BITS-1:0] d,
                                                   input logic                  square);
      logic [TERM_W-1:0] w;
      w = TERM_W'(d);
      return square ? (w * w) : w;
   endfunction

   logic [COORD_BITS-1:0] ent_x_ff, ent_x_in;
   logic [COORD_BITS-1:0] ent_y_ff, ent_y_in;
   logic [COORD_BITS-1:0] ent_z_ff, ent_z_in;
   logic [TAG_W-1:0]      ent_tag_ff, ent_tag_in;
   logic [TERM_W-1:0]     term_x_ff, term_x_in;
   logic [TERM_W-1:0]     term_y_ff, term_y_in;
   logic [TERM_W-1:0]     term_z_ff, term_z_in;
   logic [DIST_W-1:0]     dist_ff, dist_in;
   logic                  dst_valid_ff, dst_valid_in;
   logic [DIST_W-1:0]     dst_dist_ff, dst_dist_in;
   logic [IDX_W-1:0]      dst_idx_ff, dst_idx_in;
   logic [TAG_W-1:0]      dst_tag_ff, dst_tag_in;
   logic                  wr_en;
   logic                  active;
   logic                  square;
   logic [DIST_W-1:0]     sum_d;
   logic [DIST_W-1:0]     max_d;

   assign wr_en  = append && (count == CNT_W'(INDEX));
   assign active = count > CNT_W'(INDEX);
   assign square = (mode == MODE_EUCLID);

   always_comb begin
      ent_x_in   = wr_en ? wr_x   : ent_x_ff;
      ent_y_in   = wr_en ? wr_y   : ent_y_ff;
      ent_z_in   = wr_en ? wr_z   : ent_z_ff;
      ent_tag_in = wr_en ? wr_tag : ent_tag_ff;

      // per-axis terms, squared for euclidean
      term_x_in = axis_term(abs_diff(seed_x, ent_x_ff), square);
      term_y_in = axis_term(abs_diff(seed_y, ent_y_ff), square);
      term_z_in = axis_term(abs_diff(seed_z, ent_z_ff), square);

      sum_d = DIST_W'(term_x_ff) + DIST_W'(term_y_ff) + DIST_W'(term_z_ff);
      max_d = DIST_W'(term_x_ff);
      if (DIST_W'(term_y_ff) > max_d) begin
         max_d = DIST_W'(term_y_ff);
      end
      if (DIST_W'(term_z_ff) > max_d) begin
         max_d = DIST_W'(term_z_ff);
      end
      case (mode)
         MODE_EUCLID:    dist_in = sum_d;
         MODE_MANHATTAN: dist_in = sum_d;
         default:        dist_in = max_d;
      endcase

      // strict compare keeps the earliest fragment on a tie
      dst_valid_in = src_valid;
      if (active && (dist_ff < src_dist)) begin
         dst_dist_in = dist_ff;
         dst_idx_in  = IDX_W'(INDEX);
         dst_tag_in  = ent_tag_ff;
      end else begin
         dst_dist_in = src_dist;
         dst_idx_in  = src_idx;
         dst_tag_in  = src_tag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_valid_ff <= 1'b0;
      end else begin
         dst_valid_ff <= dst_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_x_ff    <= ent_x_in;
      ent_y_ff    <= ent_y_in;
      ent_z_ff    <= ent_z_in;
      ent_tag_ff  <= ent_tag_in;
      term_x_ff   <= term_x_in;
      term_y_ff   <= term_y_in;
      term_z_ff   <= term_z_in;
      dist_ff     <= dist_in;
      dst_dist_ff <= dst_dist_in;
      dst_idx_ff  <= dst_idx_in;
      dst_tag_ff  <= dst_tag_in;
   end

   assign dst_valid = dst_valid_ff;
   assign dst_dist  = dst_dist_ff;
   assign dst_idx   = dst_idx_ff;
   assign dst_tag   = dst_tag_ff;

endmodule

// ----- rtl/core/nfl_cell_row.sv -----
// row of table cells through which the best candidate walks one cell per cycle
module nfl_cell_row #(
   parameter int MAX_FRAGMENTS = nfl_pkg::MAX_FRAGMENTS_DEF,
   parameter int COORD_BITS    = nfl_pkg::COORD_BITS_DEF,
   parameter int IDX_W         = 6,
   parameter int CNT_W         = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [nfl_pkg::MODE_W-1:0]  mode,
   input  nfl_pkg::row_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]            count,
   input  logic [COORD_BITS-1:0]       seed_x,
   input  logic [COORD_BITS-1:0]       seed_y,
   input  logic [COORD_BITS-1:0]       seed_z,
   input  logic [COORD_BITS-1:0]       wr_x,
   input  logic [COORD_BITS-1:0]       wr_y,
   input  logic [COORD_BITS-1:0]       wr_z,
   input  logic [nfl_pkg::TAG_W-1:0]   wr_tag,
   output logic                        out_valid,
   output logic [IDX_W-1:0]            out_idx,
   output logic [nfl_pkg::TAG_W-1:0]   out_tag
);
   import nfl_pkg::*;

   localparam int DIST_W = 2 * COORD_BITS + 2;

   logic              tok_valid [MAX_FRAGMENTS+1];
   logic [DIST_W-1:0] tok_dist  [MAX_FRAGMENTS+1];
   logic [IDX_W-1:0]  tok_idx   [MAX_FRAGMENTS+1];
   logic [TAG_W-1:0]  tok_tag   [MAX_FRAGMENTS+1];

   // candidate enters with the largest distance so the first live cell always wins
   assign tok_valid[0] = ctrl.launch;
   assign tok_dist[0]  = '1;
   assign tok_idx[0]   = '0;
   assign tok_tag[0]   = '0;

   for (genvar i = 0; i < MAX_FRAGMENTS; i++) begin : g_cell
      nfl_cell #(
         .INDEX      (i),
         .COORD_BITS (COORD_BITS),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .mode      (mode),
         .seed_x    (seed_x),
         .seed_y    (seed_y),
         .seed_z    (seed_z),
         .append    (ctrl.append),
         .count     (count),
         .wr_x      (wr_x),
         .wr_y      (wr_y),
         .wr_z      (wr_z),
         .wr_tag    (wr_tag),
         .src_valid (tok_valid[i]),
         .src_dist  (tok_dist[i]),
         .src_idx   (tok_idx[i]),
         .src_tag   (tok_tag[i]),
         .dst_valid (tok_valid[i+1]),
         .dst_dist  (tok_dist[i+1]),
         .dst_idx   (tok_idx[i+1]),
         .dst_tag   (tok_tag[i+1])
      );
   end

   assign out_valid = tok_valid[MAX_FRAGMENTS];
   assign out_idx   = tok_idx[MAX_FRAGMENTS];
   assign out_tag   = tok_tag[MAX_FRAGMENTS];

endmodule

// ----- rtl/core/nearest_fragment_label.sv -----
// nearest fragment label: top level with command sequencer, table count and response register
// clear, append and empty-table classify: result can be taken in the cycle after acceptance
// classify: the result passes through the cell row,
// which the best candidate crosses one cell per cycle, plus term, distance, hold and output steps
// one transaction at a time; the next is taken in the cycle the previous result leaves the output
// register; reset clears the fragment count, the distance mode, the sequencer and valid flags
module nearest_fragment_label #(
   parameter int MAX_FRAGMENTS = nfl_pkg::MAX_FRAGMENTS_DEF,
   parameter int COORD_BITS    = nfl_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [nfl_pkg::CMD_W-1:0]     req_cmd,
   input  logic [nfl_pkg::POS_W-1:0]     req_pos_x,
   input  logic [nfl_pkg::POS_W-1:0]     req_pos_y,
   input  logic [nfl_pkg::POS_W-1:0]     req_pos_z,
   input  logic [nfl_pkg::TAG_W-1:0]     req_frag_tag,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [nfl_pkg::STATUS_W-1:0]  rsp_status,
   output logic [nfl_pkg::TAG_W-1:0]     rsp_nearest_tag,
   output logic [nfl_pkg::INDEX_W-1:0]   rsp_nearest_index,
   input  logic                          csr_wr_en,
   input  logic [nfl_pkg::MODE_W-1:0]    csr_wr_data
);
   import nfl_pkg::*;

   localparam int IDX_W = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
   localparam int CNT_W = $clog2(MAX_FRAGMENTS + 1);

   state_type             state_ff, state_in;
   logic [MODE_W-1:0]     mode_ff, mode_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [COORD_BITS-1:0] seed_x_ff, seed_x_in;
   logic [COORD_BITS-1:0] seed_y_ff, seed_y_in;
   logic [COORD_BITS-1:0] seed_z_ff, seed_z_in;
   logic [IDX_W-1:0]      hold_idx_ff, hold_idx_in;
   logic [TAG_W-1:0]      hold_tag_ff, hold_tag_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [INDEX_W-1:0]    rsp_index_ff, rsp_index_in;

   row_ctrl_type          row_ctrl;
   logic                  row_valid;
   logic [IDX_W-1:0]      row_idx;
   logic [TAG_W-1:0]      row_tag;
   logic                  rsp_free;
   logic                  req_take;
   logic [COORD_BITS-1:0] pos_x;
   logic [COORD_BITS-1:0] pos_y;
   logic [COORD_BITS-1:0] pos_z;

   assign pos_x = COORD_BITS'(req_pos_x);
   assign pos_y = COORD_BITS'(req_pos_y);
   assign pos_z = COORD_BITS'(req_pos_z);

   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && rsp_free);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      state_in      = state_ff;
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      count_in      = count_ff;
      seed_x_in     = seed_x_ff;
      seed_y_in     = seed_y_ff;
      seed_z_in     = seed_z_ff;
      hold_idx_in   = hold_idx_ff;
      hold_tag_in   = hold_tag_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_index_in  = rsp_index_ff;
      row_ctrl      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (req_cmd)
                  CMD_CLEAR: begin
                     count_in      = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STAT_CLEARED;
                     rsp_tag_in    = '0;
                     rsp_index_in  = '0;
                  end
                  CMD_APPEND: begin
                     rsp_valid_in = 1'b1;
                     rsp_tag_in   = '0;
                     rsp_index_in = '0;
                     if (count_ff < CNT_W'(MAX_FRAGMENTS)) begin
                        row_ctrl.append = 1'b1;
                        count_in        = count_ff + CNT_W'(1);
                        rsp_status_in   = STAT_STORED;
                     end else begin
                        rsp_status_in = STAT_FULL;
                     end
                  end
                  CMD_CLASSIFY: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                        rsp_tag_in    = '0;
                        rsp_index_in  = '0;
                     end else begin
                        seed_x_in = pos_x;
                        seed_y_in = pos_y;
                        seed_z_in = pos_z;
                        state_in  = ST_TERM;
                     end
                  end
                  default: begin
                     // unused command: taken with no result
                  end
               endcase
            end
         end
         ST_TERM: begin
            state_in = ST_DIST;
         end
         ST_DIST: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            row_ctrl.launch = 1'b1;
            state_in        = ST_SCAN;
         end
         ST_SCAN: begin
            if (row_valid) begin
               hold_idx_in = row_idx;
               hold_tag_in = row_tag;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STAT_CLASSIFIED;
               rsp_tag_in    = hold_tag_ff;
               rsp_index_in  = INDEX_W'(hold_idx_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_EUCLID;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seed_x_ff     <= seed_x_in;
      seed_y_ff     <= seed_y_in;
      seed_z_ff     <= seed_z_in;
      hold_idx_ff   <= hold_idx_in;
      hold_tag_ff   <= hold_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_index_ff  <= rsp_index_in;
   end

   nfl_cell_row #(
      .MAX_FRAGMENTS (MAX_FRAGMENTS),
      .COORD_BITS    (COORD_BITS),
      .IDX_W         (IDX_W),
      .CNT_W         (CNT_W)
   ) u_row (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .ctrl      (row_ctrl),
      .count     (count_ff),
      .seed_x    (seed_x_ff),
      .seed_y    (seed_y_ff),
      .seed_z    (seed_z_ff),
      .wr_x      (pos_x),
      .wr_y      (pos_y),
      .wr_z      (pos_z),
      .wr_tag    (req_frag_tag),
      .out_valid (row_valid),
      .out_idx   (row_idx),
      .out_tag   (row_tag)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_nearest_tag   = rsp_tag_ff;
   assign rsp_nearest_index = rsp_index_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_FRAGMENTS))
      else $error("fragment count beyond table size");

   a_row_in_scan: assert property (@(posedge clock) disable iff (reset)
      row_valid |-> (state_ff == ST_SCAN))
      else $error("candidate left the cell row outside a scan");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff == ST_DONE) || $past(req_take)))
      else $error("response appeared with no transaction behind it");

   a_classified_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STAT_CLASSIFIED)) |-> (count_ff != '0))
      else $error("classified result with an empty table");

endmodule
